### hdl/led_area_pixel_mapper_core_defines.svh
// assertion macros for the led area pixel mapper
// expects clk and rst_n in the scope of each use
`ifndef LED_AREA_PIXEL_MAPPER_CORE_DEFINES_SVH
`define LED_AREA_PIXEL_MAPPER_CORE_DEFINES_SVH

// same-cycle implication
`define LAPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LAPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/lapm_pkg.sv
// shared types, codes and constants of the led area pixel mapper
// no dependencies
`timescale 1ns / 1ps

package lapm_pkg;

    localparam int SEGMENT_ENTRIES_DEF   = 64;
    localparam int AREA_LIST_ENTRIES_DEF = 128;
    localparam int MAX_PATTERN_DEF       = 16;

    localparam logic [7:0] END_MARK   = 8'd127;
    localparam logic [7:0] IDLE_PIXEL = 8'd255;

    // quotient width of the colour division
    localparam int DIV_W = 10;

    typedef enum logic [1:0] {
        CMD_SEG_WR  = 2'd0,
        CMD_AREA_WR = 2'd1,
        CMD_START   = 2'd2,
        CMD_NEXT    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_IDLE = 2'd0,
        DIR_FWD  = 2'd1,
        DIR_REV  = 2'd2
    } dir_t;

    typedef struct packed {
        cmd_t              cmd;
        logic [6:0]        table_addr;
        logic [7:0]        length_value;
        logic signed [7:0] area_entry;
        logic [3:0]        area;
        logic [4:0]        pattern_length;
        logic [7:0]        pixel_length;
        logic [15:0]       offset_fixed;
    } req_t;

    typedef struct packed {
        logic [7:0] pixel_index;
        logic [3:0] color_index;
        logic [7:0] area_pixels;
        logic       area_done;
    } rsp_t;

    typedef enum logic [4:0] {
        OP_IDLE,
        OP_TAKE,
        OP_FIND_RD,
        OP_FIND_CHK,
        OP_CNT_RD,
        OP_CNT_CHK,
        OP_CNT_ADD,
        OP_RELOAD,
        OP_LOAD_RD,
        OP_LOAD_CHK,
        OP_SUM_RD,
        OP_SUM_ACC,
        OP_SEG_RD,
        OP_SEG_SET,
        OP_PIX,
        OP_DIV_STEP,
        OP_MOD_LOAD,
        OP_COLOR,
        OP_STEP
    } op_t;

    typedef struct packed {
        op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic find_stop;
        logic lpos_end;
        logic marker;
        logic sum_more;
        logic pl_zero;
        logic div_last;
        logic step_in;
        logic walk_idle;
    } dp_stat_t;

endpackage

### hdl/lapm_dp.sv
// datapath: segment and area tables, walk registers, serial divider
// depends on lapm_pkg
`timescale 1ns / 1ps

module lapm_dp
    import lapm_pkg::*;
#(
    parameter int SEGMENT_ENTRIES   = SEGMENT_ENTRIES_DEF,
    parameter int AREA_LIST_ENTRIES = AREA_LIST_ENTRIES_DEF,
    parameter int MAX_PATTERN       = MAX_PATTERN_DEF
)
(
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     request,
    input  dp_cmd_t  ctl,
    output dp_stat_t stat,
    output rsp_t     result
);

    localparam int SEG_AW  = $clog2(SEGMENT_ENTRIES);
    localparam int LIST_AW = $clog2(AREA_LIST_ENTRIES);
    localparam int LPOS_W  = LIST_AW + 1;

    logic [7:0] seg_mem  [SEGMENT_ENTRIES];
    logic [7:0] list_mem [AREA_LIST_ENTRIES];

    logic [SEG_AW-1:0]  seg_raddr;
    logic [LIST_AW-1:0] list_raddr;
    logic [7:0]         seg_rd_reg;
    logic [7:0]         list_rd_reg;
    logic [8:0]         wr_addr_ext;
    logic               seg_we;
    logic               list_we;

    logic [LPOS_W-1:0] lpos_reg;
    logic [LPOS_W-1:0] area_idx_reg;
    logic [3:0]        area_reg;
    logic [3:0]        fcnt_reg;
    logic [7:0]        cnt_reg;
    logic [7:0]        seg_start_reg;
    logic [7:0]        seg_len_reg;
    logic [7:0]        seg_pos_reg;
    dir_t              dir_reg;
    logic [7:0]        ord_reg;
    logic [4:0]        plen_reg;
    logic [7:0]        pl_reg;
    logic [15:0]       off_reg;
    logic [7:0]        pixels_reg;
    logic [7:0]        mag_reg;
    logic              rev_reg;
    logic [7:0]        psum_reg;
    logic [7:0]        pidx_reg;
    logic [DIV_W-1:0]  dq_reg;
    logic [7:0]        dr_reg;
    logic [7:0]        den_reg;
    logic [3:0]        dcnt_reg;
    logic [7:0]        res_pix_reg;
    logic [3:0]        res_color_reg;

    logic        entry_rev;
    logic [7:0]  entry_mag;
    logic        mag_in;
    logic [7:0]  seg_len_sel;
    logic [8:0]  cnt_sum;
    logic [7:0]  pos_inc;
    logic [17:0] num;
    logic [8:0]  trial;
    logic [8:0]  diff;
    logic        ge;
    logic [7:0]  dr_next;
    logic [4:0]  plen_c;
    logic [7:0]  pix;

    assign wr_addr_ext = 9'(request.table_addr);
    assign seg_we  = (ctl.op == OP_TAKE) && (request.cmd == CMD_SEG_WR)
                     && (wr_addr_ext < 9'(SEGMENT_ENTRIES));
    assign list_we = (ctl.op == OP_TAKE) && (request.cmd == CMD_AREA_WR)
                     && (wr_addr_ext < 9'(AREA_LIST_ENTRIES));

    assign entry_rev   = list_rd_reg[7];
    assign entry_mag   = entry_rev ? (8'd0 - list_rd_reg) : list_rd_reg;
    assign mag_in      = 9'(mag_reg) < 9'(SEGMENT_ENTRIES);
    assign seg_len_sel = mag_in ? seg_rd_reg : 8'd0;
    assign cnt_sum     = 9'(cnt_reg) + 9'((seg_len_sel == 8'd0) ? 8'd1 : seg_len_sel);
    assign pos_inc     = seg_pos_reg + 8'd1;
    assign num         = 18'({ord_reg, 8'd0}) + 18'(off_reg) + 18'({pl_reg, 7'd0});
    assign trial       = {dr_reg, dq_reg[DIV_W-1]};
    assign ge          = trial >= {1'b0, den_reg};
    assign diff        = trial - {1'b0, den_reg};
    assign dr_next     = ge ? diff[7:0] : trial[7:0];
    assign pix         = (dir_reg == DIR_REV) ? (seg_start_reg - seg_pos_reg)
                                              : (seg_start_reg + seg_pos_reg);

    always_comb
    begin
        if (request.pattern_length == 5'd0)
            plen_c = 5'd1;
        else if (9'(request.pattern_length) > 9'(MAX_PATTERN))
            plen_c = 5'(MAX_PATTERN);
        else
            plen_c = request.pattern_length;
    end

    always_comb
    begin
        unique case (ctl.op)
            OP_CNT_CHK: seg_raddr = entry_mag[SEG_AW-1:0];
            OP_SUM_RD:  seg_raddr = pidx_reg[SEG_AW-1:0];
            default:    seg_raddr = mag_reg[SEG_AW-1:0];
        endcase
    end

    assign list_raddr = lpos_reg[LIST_AW-1:0];

    always_ff @(posedge clk)
    begin
        if (seg_we)
            seg_mem[wr_addr_ext[SEG_AW-1:0]] <= request.length_value;
        seg_rd_reg <= seg_mem[seg_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (list_we)
            list_mem[wr_addr_ext[LIST_AW-1:0]] <= $unsigned(request.area_entry);
        list_rd_reg <= list_mem[list_raddr];
    end

    assign stat.lpos_end  = lpos_reg == LPOS_W'(AREA_LIST_ENTRIES);
    assign stat.find_stop = stat.lpos_end || (fcnt_reg == area_reg);
    assign stat.marker    = list_rd_reg == END_MARK;
    assign stat.sum_more  = (pidx_reg < mag_reg) && (9'(pidx_reg) < 9'(SEGMENT_ENTRIES));
    assign stat.pl_zero   = pl_reg == 8'd0;
    assign stat.div_last  = dcnt_reg == 4'(DIV_W - 1);
    assign stat.step_in   = pos_inc < seg_len_reg;
    assign stat.walk_idle = dir_reg == DIR_IDLE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lpos_reg      <= '0;
            area_idx_reg  <= '0;
            area_reg      <= '0;
            fcnt_reg      <= '0;
            cnt_reg       <= '0;
            seg_start_reg <= '0;
            seg_len_reg   <= '0;
            seg_pos_reg   <= '0;
            dir_reg       <= DIR_IDLE;
            ord_reg       <= '0;
            plen_reg      <= '0;
            pl_reg        <= '0;
            off_reg       <= '0;
            pixels_reg    <= '0;
            mag_reg       <= '0;
            rev_reg       <= 1'b0;
            psum_reg      <= '0;
            pidx_reg      <= '0;
            dq_reg        <= '0;
            dr_reg        <= '0;
            den_reg       <= '0;
            dcnt_reg      <= '0;
            res_pix_reg   <= IDLE_PIXEL;
            res_color_reg <= '0;
        end
        else
        begin
            unique case (ctl.op)
                OP_TAKE:
                begin
                    res_pix_reg   <= IDLE_PIXEL;
                    res_color_reg <= '0;
                    if (request.cmd == CMD_START)
                    begin
                        area_reg <= request.area;
                        plen_reg <= plen_c;
                        pl_reg   <= request.pixel_length;
                        off_reg  <= request.offset_fixed;
                        ord_reg  <= '0;
                        lpos_reg <= '0;
                        fcnt_reg <= '0;
                    end
                end
                OP_FIND_RD:
                begin
                    // area not found falls back to list entry 0
                    if (stat.find_stop)
                    begin
                        area_idx_reg <= stat.lpos_end ? '0 : lpos_reg;
                        lpos_reg     <= stat.lpos_end ? '0 : lpos_reg;
                        cnt_reg      <= '0;
                    end
                end
                OP_FIND_CHK:
                begin
                    if (stat.marker)
                        fcnt_reg <= fcnt_reg + 4'd1;
                    lpos_reg <= lpos_reg + LPOS_W'(1);
                end
                OP_CNT_CHK:
                begin
                    lpos_reg <= lpos_reg + LPOS_W'(1);
                    mag_reg  <= entry_mag;
                end
                OP_CNT_ADD:
                begin
                    // a zero-length segment still yields one pixel
                    cnt_reg <= cnt_sum[8] ? 8'd255 : cnt_sum[7:0];
                end
                OP_RELOAD:
                begin
                    lpos_reg    <= area_idx_reg;
                    seg_pos_reg <= '0;
                    seg_len_reg <= '0;
                    pixels_reg  <= cnt_reg;
                end
                OP_LOAD_RD:
                begin
                    if (stat.lpos_end)
                        dir_reg <= DIR_IDLE;
                end
                OP_LOAD_CHK:
                begin
                    lpos_reg <= lpos_reg + LPOS_W'(1);
                    if (stat.marker)
                        dir_reg <= DIR_IDLE;
                    else
                        dir_reg <= entry_rev ? DIR_REV : DIR_FWD;
                    mag_reg  <= entry_mag;
                    rev_reg  <= entry_rev;
                    psum_reg <= '0;
                    pidx_reg <= '0;
                end
                OP_SUM_ACC:
                begin
                    psum_reg <= psum_reg + seg_rd_reg;
                    pidx_reg <= pidx_reg + 8'd1;
                end
                OP_SEG_SET:
                begin
                    seg_len_reg   <= seg_len_sel;
                    seg_start_reg <= psum_reg
                                     + ((rev_reg && mag_in) ? (seg_len_sel - 8'd1) : 8'd0);
                    seg_pos_reg   <= '0;
                end
                OP_PIX:
                begin
                    res_pix_reg <= pix;
                    ord_reg     <= ord_reg + 8'd1;
                    dq_reg      <= num[17:8];
                    den_reg     <= pl_reg;
                    dr_reg      <= '0;
                    dcnt_reg    <= '0;
                end
                OP_DIV_STEP:
                begin
                    dq_reg   <= {dq_reg[DIV_W-2:0], ge};
                    dr_reg   <= dr_next;
                    dcnt_reg <= dcnt_reg + 4'd1;
                end
                OP_MOD_LOAD:
                begin
                    den_reg  <= 8'(plen_reg);
                    dr_reg   <= '0;
                    dcnt_reg <= '0;
                end
                OP_COLOR:
                begin
                    res_color_reg <= dr_reg[3:0];
                end
                OP_STEP:
                begin
                    seg_pos_reg <= pos_inc;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign result.pixel_index = res_pix_reg;
    assign result.color_index = res_color_reg;
    assign result.area_pixels = pixels_reg;
    assign result.area_done   = dir_reg == DIR_IDLE;

endmodule

### hdl/lapm_ctrl.sv
// controller: sequences table writes, area search, pixel count and pixel steps
// depends on lapm_pkg and led_area_pixel_mapper_core_defines.svh
`timescale 1ns / 1ps
`include "led_area_pixel_mapper_core_defines.svh"

module lapm_ctrl
    import lapm_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     start,
    input  cmd_t     cmd,
    input  dp_stat_t stat,
    output dp_cmd_t  ctl,
    output logic     busy,
    output logic     done
);

    typedef enum logic [4:0] {
        S_IDLE,
        S_FIND_RD,
        S_FIND_CHK,
        S_CNT_RD,
        S_CNT_CHK,
        S_CNT_ADD,
        S_RELOAD,
        S_LOAD_RD,
        S_LOAD_CHK,
        S_SUM_RD,
        S_SUM_ACC,
        S_SEG_RD,
        S_SEG_SET,
        S_PIX,
        S_DIV,
        S_MOD_LOAD,
        S_MOD,
        S_COLOR,
        S_STEP,
        S_RESULT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   busy_reg;
    logic   done_reg;

    always_comb
    begin
        state_next = state_reg;
        ctl.op     = OP_IDLE;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.op = OP_TAKE;
                    unique case (cmd)
                        CMD_START:               state_next = S_FIND_RD;
                        CMD_NEXT:                state_next = stat.walk_idle ? S_RESULT : S_PIX;
                        CMD_SEG_WR, CMD_AREA_WR: state_next = S_IDLE;
                    endcase
                end
            end
            S_FIND_RD:
            begin
                ctl.op     = OP_FIND_RD;
                state_next = stat.find_stop ? S_CNT_RD : S_FIND_CHK;
            end
            S_FIND_CHK:
            begin
                ctl.op     = OP_FIND_CHK;
                state_next = S_FIND_RD;
            end
            S_CNT_RD:
            begin
                ctl.op     = OP_CNT_RD;
                state_next = stat.lpos_end ? S_RELOAD : S_CNT_CHK;
            end
            S_CNT_CHK:
            begin
                ctl.op     = OP_CNT_CHK;
                state_next = stat.marker ? S_RELOAD : S_CNT_ADD;
            end
            S_CNT_ADD:
            begin
                ctl.op     = OP_CNT_ADD;
                state_next = S_CNT_RD;
            end
            S_RELOAD:
            begin
                ctl.op     = OP_RELOAD;
                state_next = S_LOAD_RD;
            end
            S_LOAD_RD:
            begin
                ctl.op     = OP_LOAD_RD;
                state_next = stat.lpos_end ? S_RESULT : S_LOAD_CHK;
            end
            S_LOAD_CHK:
            begin
                ctl.op     = OP_LOAD_CHK;
                state_next = stat.marker ? S_RESULT : S_SUM_RD;
            end
            S_SUM_RD:
            begin
                ctl.op     = OP_SUM_RD;
                state_next = stat.sum_more ? S_SUM_ACC : S_SEG_RD;
            end
            S_SUM_ACC:
            begin
                ctl.op     = OP_SUM_ACC;
                state_next = S_SUM_RD;
            end
            S_SEG_RD:
            begin
                ctl.op     = OP_SEG_RD;
                state_next = S_SEG_SET;
            end
            S_SEG_SET:
            begin
                ctl.op     = OP_SEG_SET;
                state_next = S_RESULT;
            end
            S_PIX:
            begin
                ctl.op     = OP_PIX;
                state_next = stat.pl_zero ? S_STEP : S_DIV;
            end
            S_DIV:
            begin
                ctl.op     = OP_DIV_STEP;
                state_next = stat.div_last ? S_MOD_LOAD : S_DIV;
            end
            S_MOD_LOAD:
            begin
                ctl.op     = OP_MOD_LOAD;
                state_next = S_MOD;
            end
            S_MOD:
            begin
                ctl.op     = OP_DIV_STEP;
                state_next = stat.div_last ? S_COLOR : S_MOD;
            end
            S_COLOR:
            begin
                ctl.op     = OP_COLOR;
                state_next = S_STEP;
            end
            S_STEP:
            begin
                ctl.op     = OP_STEP;
                state_next = stat.step_in ? S_RESULT : S_LOAD_RD;
            end
            S_RESULT:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            busy_reg  <= state_next != S_IDLE;
            done_reg  <= state_next == S_RESULT;
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;

    `LAPM_ASSERT_NEXT(a_done_single, done, !done, "result strobe held longer than one cycle")
    `LAPM_ASSERT_NEXT(a_write_no_busy,
        start && !busy && (cmd == CMD_SEG_WR || cmd == CMD_AREA_WR),
        !busy && !done, "table write request raised busy or a result")
    `LAPM_ASSERT_NEXT(a_start_busy, start && !busy && cmd == CMD_START, busy,
        "start request did not raise busy")
    `LAPM_ASSERT_NEXT(a_div_exit, state_reg == S_DIV,
        state_reg == S_DIV || state_reg == S_MOD_LOAD, "divider left by a wrong path")

endmodule

### hdl/led_area_pixel_mapper_core.sv
// top level of the led area pixel mapper: controller plus datapath
// depends on lapm_pkg, lapm_ctrl and lapm_dp
//
// channel   direction  handshake              payload
// request   in         start and not busy     req_t
// result    out        done, one cycle only   rsp_t
//
// table writes leave busy low
// start: walks the list entries up to the area, counts each segment of it, then sums
//   the lengths ahead of the first segment for its start (prefix walk over seg table)
// next pixel: steps through the two serial divisions to the result strobe and skips
//   them when pixel_length is 0; loading a new segment adds a prefix walk over seg table
// reset clears all walk state; tables hold no reset value; results cannot be stalled
`timescale 1ns / 1ps

module led_area_pixel_mapper_core
    import lapm_pkg::*;
#(
    parameter int SEGMENT_ENTRIES   = SEGMENT_ENTRIES_DEF,
    parameter int AREA_LIST_ENTRIES = AREA_LIST_ENTRIES_DEF,
    parameter int MAX_PATTERN       = MAX_PATTERN_DEF
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic start,
    output logic busy,
    input  req_t request,
    output logic done,
    output rsp_t result
);

    dp_cmd_t  ctl;
    dp_stat_t stat;

    lapm_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .cmd   (request.cmd),
        .stat  (stat),
        .ctl   (ctl),
        .busy  (busy),
        .done  (done)
    );

    lapm_dp #(
        .SEGMENT_ENTRIES   (SEGMENT_ENTRIES),
        .AREA_LIST_ENTRIES (AREA_LIST_ENTRIES),
        .MAX_PATTERN       (MAX_PATTERN)
    ) u_dp (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .ctl     (ctl),
        .stat    (stat),
        .result  (result)
    );

endmodule

### test/led_area_pixel_mapper_core_test.sv
// self-checking testbench for led_area_pixel_mapper_core: table loads, area starts and pixel walks
// checked against a scoreboard that predicts every result; depends on lapm_pkg and the core
`timescale 1ns / 1ps

module led_area_pixel_mapper_core_test;
    import lapm_pkg::*;

    localparam int SEG_N     = SEGMENT_ENTRIES_DEF;
    localparam int LIST_N    = AREA_LIST_ENTRIES_DEF;
    localparam int PAT_MAX   = MAX_PATTERN_DEF;
    localparam int CYCLE_CAP = 2000000;
    localparam int REQ_W     = $bits(req_t);

    class pixel_scoreboard;
        logic [7:0]  seg_tab [SEG_N];
        logic [7:0]  list_tab [LIST_N];
        int unsigned list_pos;
        logic [7:0]  seg_base;
        logic [7:0]  seg_size;
        logic [7:0]  seg_step;
        logic [7:0]  ordinal;
        dir_t        walk;
        int unsigned pat_len;
        int unsigned pix_len;
        int unsigned shift;
        int unsigned pixels;
        rsp_t        expected_q[$];
        int          mismatches;

        function new();
            list_pos = 0;
            seg_base = 0;
            seg_size = 0;
            seg_step = 0;
            ordinal = 0;
            walk = DIR_IDLE;
            pat_len = 0;
            pix_len = 0;
            shift = 0;
            pixels = 0;
            mismatches = 0;
        endfunction

        // move along the walk; 0 once the area is finished
        function bit walk_step(input logic [7:0] inc);
            logic [7:0]  ent;
            logic [7:0]  sum;
            int unsigned mag;
            bit          rev;
            sum = 0;
            seg_step = seg_step + inc;
            if (seg_step < seg_size)
                return 1;
            if (list_pos >= LIST_N)
            begin
                walk = DIR_IDLE;
                return 0;
            end
            ent = list_tab[list_pos];
            list_pos++;
            if (ent == END_MARK)
            begin
                walk = DIR_IDLE;
                return 0;
            end
            rev = ent[7];
            mag = rev ? 256 - int'(ent) : int'(ent);
            walk = rev ? DIR_REV : DIR_FWD;
            for (int i = 0; i < mag && i < SEG_N; i++)
                sum = sum + seg_tab[i];
            if (mag < SEG_N)
            begin
                seg_size = seg_tab[mag];
                if (rev)
                    sum = sum + seg_size - 8'd1;
            end
            else
                seg_size = 0;
            seg_base = sum;
            seg_step = 0;
            return 1;
        endfunction

        function int unsigned area_origin(input int unsigned a);
            int unsigned count;
            count = 0;
            for (int i = 0; i < LIST_N; i++)
            begin
                if (count == a)
                    return i;
                if (list_tab[i] == END_MARK)
                    count++;
            end
            return 0;
        endfunction

        function void note(input req_t r);
            rsp_t        e;
            logic [7:0]  pix;
            int unsigned color;
            int unsigned origin;
            int unsigned count;
            pix = IDLE_PIXEL;
            color = 0;
            case (r.cmd)
                CMD_SEG_WR:
                begin
                    if (r.table_addr < SEG_N)
                        seg_tab[r.table_addr[5:0]] = r.length_value;
                    return;
                end
                CMD_AREA_WR:
                begin
                    list_tab[r.table_addr] = r.area_entry;
                    return;
                end
                CMD_START:
                begin
                    origin = area_origin(r.area);
                    pat_len = r.pattern_length;
                    if (pat_len == 0)
                        pat_len = 1;
                    if (pat_len > PAT_MAX)
                        pat_len = PAT_MAX;
                    pix_len = r.pixel_length;
                    shift = r.offset_fixed;
                    list_pos = origin;
                    seg_step = 0;
                    seg_size = 0;
                    count = 0;
                    while (walk_step(8'd1))
                        if (count < 255)
                            count++;
                    pixels = count;
                    list_pos = origin;
                    seg_step = 0;
                    seg_size = 0;
                    void'(walk_step(8'd0));
                    ordinal = 0;
                end
                default:
                begin
                    if (walk != DIR_IDLE)
                    begin
                        pix = (walk == DIR_REV) ? seg_base - seg_step : seg_base + seg_step;
                        if (pix_len != 0)
                            color = ((int'(ordinal) * 256 + shift + pix_len * 128)
                                     / (pix_len * 256)) % pat_len;
                        ordinal = ordinal + 8'd1;
                        void'(walk_step(8'd1));
                    end
                end
            endcase
            e.pixel_index = pix;
            e.color_index = color[3:0];
            e.area_pixels = pixels[7:0];
            e.area_done = (walk == DIR_IDLE);
            expected_q.push_back(e);
        endfunction

        function void check(input rsp_t got);
            rsp_t e;
            if (expected_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", got);
                return;
            end
            e = expected_q.pop_front();
            if (got.pixel_index !== e.pixel_index || got.color_index !== e.color_index ||
                got.area_pixels !== e.area_pixels || got.area_done !== e.area_done)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected %p, got %p", e, got);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    logic done;
    req_t request;
    rsp_t result;

    pixel_scoreboard board;
    int gap_pct;
    int cycles;
    int sent;

    led_area_pixel_mapper_core dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_CAP)
        begin
            $display("Test completed with failures");
            $finish;
        end
    end

    always @(posedge clk)
        if (rst_n && done)
            board.check(result);

    function automatic req_t any_request(input cmd_t c);
        req_t r;
        r = req_t'(REQ_W'({$urandom, $urandom}));
        r.cmd = c;
        return r;
    endfunction

    task automatic send(input req_t r);
        @(negedge clk);
        start = 1;
        request = r;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        board.note(r);
        sent++;
        if ($urandom_range(99) < gap_pct)
        begin
            @(negedge clk);
            start = 0;
            repeat ($urandom_range(0, 3)) @(negedge clk);
        end
    endtask

    task automatic write_len(input int a, input int v);
        req_t r;
        r = any_request(CMD_SEG_WR);
        r.table_addr = 7'(a);
        r.length_value = 8'(v);
        send(r);
    endtask

    task automatic write_entry(input int a, input int v);
        req_t r;
        r = any_request(CMD_AREA_WR);
        r.table_addr = 7'(a);
        r.area_entry = 8'(v);
        send(r);
    endtask

    task automatic begin_area(input int a, input int plen, input int pl, input int ofs);
        req_t r;
        r = any_request(CMD_START);
        r.area = 4'(a);
        r.pattern_length = 5'(plen);
        r.pixel_length = 8'(pl);
        r.offset_fixed = 16'(ofs);
        send(r);
    endtask

    task automatic next_pixels(input int n);
        repeat (n) send(any_request(CMD_NEXT));
    endtask

    // sender holds off until every outstanding request has answered
    task automatic drain();
        @(negedge clk);
        start = 0;
        while (board.expected_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic random_part(input int quota);
        int stop;
        int pick;
        int n;
        stop = sent + quota;
        while (sent < stop)
        begin
            pick = $urandom_range(99);
            if (pick < 8)
                write_len($urandom_range(127),
                          ($urandom_range(19) == 0) ? $urandom_range(255) : $urandom_range(8));
            else if (pick < 14)
                write_entry($urandom_range(127),
                            ($urandom_range(2) == 0) ? 127 : $urandom_range(0, 255));
            else
            begin
                begin_area($urandom_range(15), $urandom_range(31), $urandom_range(255),
                           $urandom_range(65535));
                if ($urandom_range(9) == 0)
                    n = board.pixels + 1;
                else
                begin
                    n = $urandom_range(1, 12);
                    if (n > board.pixels)
                        n = board.pixels;
                    n = n + $urandom_range(1);
                end
                next_pixels(n);
            end
        end
    endtask

    initial
    begin
        board = new();
        cycles = 0;
        sent = 0;
        gap_pct = 7;
        start = 0;
        request = '0;
        rst_n = 0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // every table entry written before any walk reads it
        for (int i = 0; i < SEG_N; i++)
            write_len(i, (i == 5 || i == 63) ? 255 : i % 7);
        // sparse markers: long areas, pixel count saturates, last area runs off the list
        for (int i = 0; i < LIST_N; i++)
            if (i % 40 == 39)
                write_entry(i, 127);
            else if (i == 10)
                write_entry(i, -128);
            else if (i == 20)
                write_entry(i, 100);
            else
                write_entry(i, (i % 2) ? -(i % 9) : i % 9 + 1);

        begin_area(0, 0, 0, 0);
        next_pixels(3);
        begin_area(3, 31, 1, 16'hffff);
        next_pixels(3);
        begin_area(15, 16, 255, 16'h0080);
        next_pixels(2);
        begin_area(1, 17, 128, 16'h8000);
        next_pixels(2);
        write_len(64, 9);
        write_len(127, 200);
        // empty area, then a next pixel while idle
        write_entry(0, 127);
        begin_area(0, 1, 2, 0);
        next_pixels(2);

        // denser area lists for the random part
        for (int i = 0; i < LIST_N; i++)
            if ($urandom_range(3) == 0)
                write_entry(i, 127);
            else if ($urandom_range(9) == 0)
                write_entry(i, $urandom_range(0, 255));
            else
                write_entry(i, $urandom_range(0, 20) - 10);

        random_part(35);
        drain();
        gap_pct = 49;
        random_part(35);
        drain();
        gap_pct = 0;
        random_part(35);

        @(negedge clk);
        start = 0;
        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (300) @(posedge clk);
        if (board.mismatches == 0 && board.expected_q.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
